>>> src/pip_pkg.sv
// Package of the packed identifier pool: widths, status codes and the result word type.
package pip_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int ID_W = 32;
  localparam int SLOT_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     result_id;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  live_count;
  } result_t;

endpackage

>>> src/pip_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/pip_engine.sv
// Request sequencer of the identifier pool: create, destroy scan and swap-remove on the id memory.
module pip_engine import pip_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [ID_W-1:0]             target_id,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [ID_W-1:0]             wr_data,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  logic [ID_W-1:0]             rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output result_t                     res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LAST,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t           state;
  logic             req_mode;
  logic [ID_W-1:0]  req_target;
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  next_id;
  logic [ID_W-1:0]  last_word;
  logic [IDX_W-1:0] rd_slot;

  logic full;
  logic match;
  logic at_last;

  assign full      = count >= CNT_W'(CAPACITY);
  assign match     = rd_data == req_target;
  assign at_last   = CNT_W'(rd_slot) == count - CNT_W'(1);
  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_HOLD;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_data = last_word;
    rd_addr = '0;
    case (state)
      S_EXEC: begin
        wr_en   = !req_mode && !full;
        wr_addr = IDX_W'(count);
        wr_data = next_id;
        rd_addr = IDX_W'(count - CNT_W'(1));
      end
      S_SCAN: begin
        wr_en   = match;
        rd_addr = IDX_W'(rd_slot + IDX_W'(1));
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      next_id <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_mode   <= mode;
            req_target <= target_id;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!req_mode) begin
            if (full) begin
              res   <= '{ST_FULL, '0, '0, COUNT_W'(count)};
            end else begin
              res     <= '{ST_OK, next_id, SLOT_W'(count), COUNT_W'(count + CNT_W'(1))};
              count   <= count + CNT_W'(1);
              next_id <= next_id + ID_W'(1);
            end
            state <= S_HOLD;
          end else if (count == '0) begin
            res   <= '{ST_MISSING, '0, '0, COUNT_W'(count)};
            state <= S_HOLD;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          last_word <= rd_data;
          rd_slot   <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (match) begin
            res   <= '{ST_OK, req_target, SLOT_W'(rd_slot), COUNT_W'(count - CNT_W'(1))};
            count <= count - CNT_W'(1);
            state <= S_HOLD;
          end else if (at_last) begin
            res   <= '{ST_MISSING, '0, '0, COUNT_W'(count)};
            state <= S_HOLD;
          end else begin
            rd_slot <= IDX_W'(rd_slot + IDX_W'(1));
          end
        end
        S_HOLD: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/pip_out_reg.sv
// Output register of the identifier pool: holds one result word until the consumer takes it.
module pip_out_reg import pip_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  result_t            res,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [ID_W-1:0]    result_id,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [COUNT_W-1:0] live_count
);

  result_t word;

  assign res_ready  = !out_valid || out_ready;
  assign status     = word.status;
  assign result_id  = word.result_id;
  assign slot_index = word.slot_index;
  assign live_count = word.live_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      word <= res;
    end
  end

endmodule

>>> src/packed_id_pool.sv
// Top level of the packed identifier pool: sequencer, id memory and output register.
//
// The pool keeps up to CAPACITY live 32-bit identifiers packed in slots 0 to count-1 of one
// synchronous memory. One request word is taken at a time; the next is accepted as soon as the
// previous result has moved to the output register, even while that result is still waiting.
// A create forms its result in the execute state; the result is then held until the output
// register takes it. A destroy first fetches the last entry through the single read port of
// the id memory and then compares one slot per cycle, up to and including the matching slot,
// or every live slot when nothing matches. A destroy on an empty pool gives its result from
// the execute state without a scan. The memory needs no clearing after reset, since only data
// read from slots below the live count is ever used.
module packed_id_pool import pip_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [ID_W-1:0]    target_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [ID_W-1:0]    result_id,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [COUNT_W-1:0] live_count
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  pip_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .target_id (target_id),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pip_ram #(
    .WIDTH(ID_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .result_id  (result_id),
    .slot_index (slot_index),
    .live_count (live_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while a previous request was still being worked on.");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !in_ready && !res_valid)
    else $error("Id memory written outside the working states.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("Pending result changed before the output register took it.");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid && !res_valid)
    else $error("Handed-over result did not appear at the output.");

endmodule
